FILE: hw/rtl/lgse_pkg.sv
// Shared types and constants for the life grid step engine.
// No dependencies; used by life_grid_step_engine, lgse_ctrl and lgse_dpath.
`default_nettype none

package lgse_pkg;

    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int SUM_W      = 11;

    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP   = 2'd2;

    localparam logic [2:0] CMD_WRITE  = 3'd0;
    localparam logic [2:0] CMD_READ   = 3'd1;
    localparam logic [2:0] CMD_TOGGLE = 3'd2;
    localparam logic [2:0] CMD_STEP   = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    typedef enum logic [2:0] {
        RES_NONE   = 3'd0,
        RES_COORD  = 3'd1,
        RES_CELL   = 3'd2,
        RES_STEP   = 3'd3,
        RES_REFUSE = 3'd4
    } res_kind_t;

    typedef struct packed {
        logic      latch_in;
        logic      cell_wr;
        logic      cell_rd;
        logic      toggle_wr;
        logic      clr_en;
        logic      sweep_init;
        logic      copy_en;
        logic      calc_en;
        logic      res_load;
        res_kind_t res_kind;
    } ctrl_t;

    typedef struct packed {
        logic [2:0] cmd;
        logic       coord_bad;
        logic       wrap_on;
        logic       clr_last;
        logic       copy_last;
        logic       calc_last;
    } stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/life_grid_step_engine.sv
// Life grid step engine: B3/S23 on a toroidal grid of byte cells.
// Depends on lgse_pkg; instantiates lgse_ctrl and lgse_dpath.
//
// Input channel (in_valid/in_stall) takes one command word: write, read or
// toggle a cell, step a generation, or clear the grid. Output channel
// (out_valid/out_stall) returns exactly one result word per command.
// One command is worked at a time; the next is taken once the result sits in
// the output register, even if the receiver has not yet taken it.
// A step copies the grid in use (w by h) into the copy memory, then for each
// cell reads its nine cells of the copy memory one at a time and writes the
// next value to the grid. A clear zeroes all MAX_COLUMNS*MAX_ROWS cells.
// Reset clears all MAX_COLUMNS*MAX_ROWS cells in one pass with
// in_stall high; configuration writes are taken at any time.
// A stalled result holds; the block then waits before loading the next one.
`default_nettype none

module life_grid_step_engine #(
    parameter int MAX_COLUMNS = lgse_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = lgse_pkg::DEF_MAX_ROWS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [lgse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lgse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [2:0]                      command,
    input  wire logic [5:0]                      x_coord,
    input  wire logic [5:0]                      y_coord,
    input  wire logic [7:0]                      write_value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [7:0]                           cell_value,
    output logic                                 coord_error,
    output logic                                 bad_cell_seen,
    output logic                                 wrap_refused
);

    lgse_pkg::ctrl_t ctrl;
    lgse_pkg::stat_t stat;

    lgse_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .ctrl      (ctrl),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    lgse_dpath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .write_value   (write_value),
        .ctrl          (ctrl),
        .stat          (stat),
        .cell_value    (cell_value),
        .coord_error   (coord_error),
        .bad_cell_seen (bad_cell_seen),
        .wrap_refused  (wrap_refused)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/lgse_dpath.sv
// Datapath: grid and copy memories, sweep counters, neighbour sum, result word.
// Depends on lgse_pkg; driven by lgse_ctrl.
`default_nettype none

module lgse_dpath #(
    parameter int MAX_COLUMNS = lgse_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = lgse_pkg::DEF_MAX_ROWS
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [lgse_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lgse_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic [2:0]                      command,
    input  wire logic [5:0]                      x_coord,
    input  wire logic [5:0]                      y_coord,
    input  wire logic [7:0]                      write_value,
    input  wire lgse_pkg::ctrl_t                 ctrl,
    output lgse_pkg::stat_t                      stat,
    output logic [7:0]                           cell_value,
    output logic                                 coord_error,
    output logic                                 bad_cell_seen,
    output logic                                 wrap_refused
);

    localparam int CELLS = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int XW    = $clog2(MAX_COLUMNS);
    localparam int YW    = $clog2(MAX_ROWS);
    localparam int WW    = $clog2(MAX_COLUMNS + 1);
    localparam int HW    = $clog2(MAX_ROWS + 1);
    localparam int SW    = lgse_pkg::SUM_W;

    function automatic logic [AW-1:0] lin(input logic [XW-1:0] fx, input logic [YW-1:0] fy);
        lin = AW'(fy) * AW'(MAX_COLUMNS) + AW'(fx);
    endfunction

    logic [7:0] grid_mem [CELLS];
    logic [7:0] copy_mem [CELLS];

    logic [6:0]    width_reg, height_reg;
    logic          wrap_reg;
    logic [2:0]    cmd_reg;
    logic [5:0]    xin_reg, yin_reg;
    logic [7:0]    wv_reg;
    logic [XW-1:0] x_cnt_reg, x_cnt_next;
    logic [YW-1:0] y_cnt_reg, y_cnt_next;
    logic [3:0]    nb_cnt_reg, nb_cnt_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          cp_wr_reg;
    logic [AW-1:0] cp_addr_reg;
    logic [SW-1:0] sum_reg;
    logic [7:0]    centre_reg;
    logic          bad_reg;
    logic [7:0]    grid_rd_reg, copy_rd_reg;
    logic [7:0]    value_reg;
    logic          coord_reg, badout_reg, refuse_reg;

    logic [WW-1:0] w_use;
    logic [HW-1:0] h_use;
    logic [AW-1:0] cell_addr, here_addr;
    logic          x_last, y_last, xy_last;
    logic [XW-1:0] xm, xp, nx;
    logic [YW-1:0] ym, yp, ny;
    logic [SW-1:0] fsum;
    logic [7:0]    next_val, tog_val;
    logic          next_bad, calc_wr, copy_re;
    logic          grid_we, grid_re;
    logic [AW-1:0] grid_wa, grid_ra;
    logic [7:0]    grid_wd;

    always_comb
    begin
        if (width_reg == 7'd0)
            w_use = WW'(1);
        else if (32'(width_reg) > 32'(MAX_COLUMNS))
            w_use = WW'(MAX_COLUMNS);
        else
            w_use = WW'(width_reg);
        if (height_reg == 7'd0)
            h_use = HW'(1);
        else if (32'(height_reg) > 32'(MAX_ROWS))
            h_use = HW'(MAX_ROWS);
        else
            h_use = HW'(height_reg);
    end

    assign cell_addr = AW'(yin_reg) * AW'(MAX_COLUMNS) + AW'(xin_reg);
    assign here_addr = lin(x_cnt_reg, y_cnt_reg);
    assign x_last    = (32'(x_cnt_reg) + 1 == 32'(w_use));
    assign y_last    = (32'(y_cnt_reg) + 1 == 32'(h_use));
    assign xy_last   = x_last && y_last;
    assign xm = (x_cnt_reg == '0) ? XW'(32'(w_use) - 1) : x_cnt_reg - 1'b1;
    assign xp = x_last ? '0 : x_cnt_reg + 1'b1;
    assign ym = (y_cnt_reg == '0) ? YW'(32'(h_use) - 1) : y_cnt_reg - 1'b1;
    assign yp = y_last ? '0 : y_cnt_reg + 1'b1;

    always_comb
    begin
        unique case (nb_cnt_reg)
            4'd0:    begin nx = xm;        ny = ym;        end
            4'd1:    begin nx = x_cnt_reg; ny = ym;        end
            4'd2:    begin nx = xp;        ny = ym;        end
            4'd3:    begin nx = xm;        ny = y_cnt_reg; end
            4'd5:    begin nx = xp;        ny = y_cnt_reg; end
            4'd6:    begin nx = xm;        ny = yp;        end
            4'd7:    begin nx = x_cnt_reg; ny = yp;        end
            4'd8:    begin nx = xp;        ny = yp;        end
            default: begin nx = x_cnt_reg; ny = y_cnt_reg; end
        endcase
    end

    assign copy_re = ctrl.calc_en && (nb_cnt_reg < 4'd9);
    assign calc_wr = ctrl.calc_en && (nb_cnt_reg == 4'd9);
    assign fsum    = sum_reg + SW'(copy_rd_reg);
    assign tog_val = (grid_rd_reg == 8'd1) ? 8'd0 : 8'd1;

    always_comb
    begin
        next_bad = 1'b0;
        if (centre_reg == 8'd1)
            next_val = (fsum == SW'(2) || fsum == SW'(3)) ? 8'd1 : 8'd0;
        else if (centre_reg == 8'd0)
            next_val = (fsum == SW'(3)) ? 8'd1 : 8'd0;
        else
        begin
            next_val = 8'd0;
            next_bad = 1'b1;
        end
    end

    always_comb
    begin
        grid_we = 1'b1;
        grid_wa = cell_addr;
        grid_wd = wv_reg;
        priority if (ctrl.clr_en)
        begin
            grid_wa = clr_cnt_reg;
            grid_wd = 8'd0;
        end
        else if (ctrl.cell_wr)
            grid_wd = wv_reg;
        else if (ctrl.toggle_wr)
            grid_wd = tog_val;
        else if (calc_wr)
        begin
            grid_wa = here_addr;
            grid_wd = next_val;
        end
        else
            grid_we = 1'b0;
    end

    assign grid_re = ctrl.copy_en || ctrl.cell_rd;
    assign grid_ra = ctrl.copy_en ? here_addr : cell_addr;

    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_wa] <= grid_wd;
        if (grid_re)
            grid_rd_reg <= grid_mem[grid_ra];
    end

    always_ff @(posedge clk)
    begin
        if (cp_wr_reg)
            copy_mem[cp_addr_reg] <= grid_rd_reg;
        if (copy_re)
            copy_rd_reg <= copy_mem[lin(nx, ny)];
    end

    always_comb
    begin
        x_cnt_next  = x_cnt_reg;
        y_cnt_next  = y_cnt_reg;
        nb_cnt_next = nb_cnt_reg;
        if (ctrl.sweep_init)
        begin
            x_cnt_next  = '0;
            y_cnt_next  = '0;
            nb_cnt_next = '0;
        end
        else if (ctrl.copy_en || calc_wr)
        begin
            nb_cnt_next = '0;
            if (x_last)
            begin
                x_cnt_next = '0;
                y_cnt_next = y_last ? '0 : y_cnt_reg + 1'b1;
            end
            else
                x_cnt_next = x_cnt_reg + 1'b1;
        end
        else if (ctrl.calc_en)
            nb_cnt_next = nb_cnt_reg + 4'd1;
        if (ctrl.clr_en)
            clr_cnt_next = (clr_cnt_reg == AW'(CELLS - 1)) ? '0 : clr_cnt_reg + 1'b1;
        else
            clr_cnt_next = clr_cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg   <= 7'(MAX_COLUMNS < 64 ? MAX_COLUMNS : 64);
            height_reg  <= 7'(MAX_ROWS < 64 ? MAX_ROWS : 64);
            wrap_reg    <= 1'b1;
            x_cnt_reg   <= '0;
            y_cnt_reg   <= '0;
            nb_cnt_reg  <= '0;
            clr_cnt_reg <= '0;
            cp_wr_reg   <= 1'b0;
            bad_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == lgse_pkg::REG_WIDTH)
                    width_reg <= cfg_data;
                else if (cfg_index == lgse_pkg::REG_HEIGHT)
                    height_reg <= cfg_data;
                else if (cfg_index == lgse_pkg::REG_WRAP)
                    wrap_reg <= cfg_data[0];
            end
            x_cnt_reg   <= x_cnt_next;
            y_cnt_reg   <= y_cnt_next;
            nb_cnt_reg  <= nb_cnt_next;
            clr_cnt_reg <= clr_cnt_next;
            cp_wr_reg   <= ctrl.copy_en;
            if (ctrl.latch_in)
                bad_reg <= 1'b0;
            else if (calc_wr && next_bad)
                bad_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            cmd_reg <= command;
            xin_reg <= x_coord;
            yin_reg <= y_coord;
            wv_reg  <= write_value;
        end
        cp_addr_reg <= here_addr;
        if (ctrl.calc_en)
        begin
            if (nb_cnt_reg == 4'd0)
                sum_reg <= '0;
            else if (nb_cnt_reg == 4'd5)
                centre_reg <= copy_rd_reg;
            else if (nb_cnt_reg < 4'd9)
                sum_reg <= fsum;
        end
        if (ctrl.res_load)
        begin
            value_reg  <= 8'd0;
            coord_reg  <= 1'b0;
            badout_reg <= 1'b0;
            refuse_reg <= 1'b0;
            unique case (ctrl.res_kind)
                lgse_pkg::RES_COORD:  coord_reg  <= 1'b1;
                lgse_pkg::RES_STEP:   badout_reg <= bad_reg;
                lgse_pkg::RES_REFUSE: refuse_reg <= 1'b1;
                lgse_pkg::RES_CELL:
                begin
                    if (cmd_reg == lgse_pkg::CMD_WRITE)
                        value_reg <= wv_reg;
                    else if (cmd_reg == lgse_pkg::CMD_TOGGLE)
                        value_reg <= tog_val;
                    else
                        value_reg <= grid_rd_reg;
                end
                default: value_reg <= 8'd0;
            endcase
        end
    end

    assign stat.cmd       = cmd_reg;
    assign stat.coord_bad = (32'(xin_reg) >= 32'(w_use)) || (32'(yin_reg) >= 32'(h_use));
    assign stat.wrap_on   = wrap_reg;
    assign stat.clr_last  = (clr_cnt_reg == AW'(CELLS - 1));
    assign stat.copy_last = xy_last;
    assign stat.calc_last = calc_wr && xy_last;

    assign cell_value    = value_reg;
    assign coord_error   = coord_reg;
    assign bad_cell_seen = badout_reg;
    assign wrap_refused  = refuse_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lgse_ctrl.sv
// Controller state machine: sequences cell commands, clears and generation steps.
// Depends on lgse_pkg; drives lgse_dpath through ctrl_t.
`default_nettype none

module lgse_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire logic            out_stall,
    input  wire lgse_pkg::stat_t stat,
    output lgse_pkg::ctrl_t      ctrl,
    output logic                 in_stall,
    output logic                 out_valid
);

    typedef enum logic [8:0] {
        S_INIT     = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_DECODE   = 9'b000000100,
        S_CELL     = 9'b000001000,
        S_CLEAR    = 9'b000010000,
        S_COPY     = 9'b000100000,
        S_COPY_END = 9'b001000000,
        S_CALC     = 9'b010000000,
        S_RESP     = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    lgse_pkg::res_kind_t kind_reg, kind_next;
    logic                out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        ctrl           = '0;
        ctrl.res_kind  = kind_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_INIT:
            begin
                ctrl.clr_en = 1'b1;
                if (stat.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    ctrl.latch_in = 1'b1;
                    state_next    = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_RESP;
                kind_next  = lgse_pkg::RES_NONE;
                if (stat.cmd == lgse_pkg::CMD_WRITE || stat.cmd == lgse_pkg::CMD_READ
                    || stat.cmd == lgse_pkg::CMD_TOGGLE)
                begin
                    kind_next = stat.coord_bad ? lgse_pkg::RES_COORD : lgse_pkg::RES_CELL;
                    if (!stat.coord_bad && stat.cmd == lgse_pkg::CMD_WRITE)
                        ctrl.cell_wr = 1'b1;
                    else if (!stat.coord_bad)
                    begin
                        ctrl.cell_rd = 1'b1;
                        state_next   = S_CELL;
                    end
                end
                else if (stat.cmd == lgse_pkg::CMD_STEP)
                begin
                    if (!stat.wrap_on)
                        kind_next = lgse_pkg::RES_REFUSE;
                    else
                    begin
                        ctrl.sweep_init = 1'b1;
                        state_next      = S_COPY;
                    end
                end
                else if (stat.cmd == lgse_pkg::CMD_CLEAR)
                    state_next = S_CLEAR;
            end
            S_CELL:
            begin
                ctrl.toggle_wr = (stat.cmd == lgse_pkg::CMD_TOGGLE);
                state_next     = S_RESP;
            end
            S_CLEAR:
            begin
                ctrl.clr_en = 1'b1;
                if (stat.clr_last)
                    state_next = S_RESP;
            end
            S_COPY:
            begin
                ctrl.copy_en = 1'b1;
                if (stat.copy_last)
                    state_next = S_COPY_END;
            end
            S_COPY_END:
            begin
                ctrl.sweep_init = 1'b1;
                state_next      = S_CALC;
            end
            S_CALC:
            begin
                ctrl.calc_en = 1'b1;
                if (stat.calc_last)
                begin
                    kind_next  = lgse_pkg::RES_STEP;
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    ctrl.res_load  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            kind_reg      <= lgse_pkg::RES_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/lgse_checker.sv
// Port-level checker for life_grid_step_engine, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module lgse_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_stall,
    input wire logic       out_valid,
    input wire logic       out_stall,
    input wire logic [7:0] cell_value,
    input wire logic       coord_error,
    input wire logic       bad_cell_seen,
    input wire logic       wrap_refused
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(cell_value) && $stable(coord_error))
        else $error("stalled result word changed");

    a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $countones({coord_error, bad_cell_seen, wrap_refused}) <= 1)
        else $error("more than one flag set");

    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (coord_error || bad_cell_seen || wrap_refused) |-> cell_value == 8'd0)
        else $error("flagged word carries a cell value");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word taken before the first was worked");

endmodule

bind life_grid_step_engine lgse_checker u_lgse_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cell_value    (cell_value),
    .coord_error   (coord_error),
    .bad_cell_seen (bad_cell_seen),
    .wrap_refused  (wrap_refused)
);

`default_nettype wire

FILE: bench/tb_life_grid_step_engine.sv
// Testbench for life_grid_step_engine: directed and random command words
// checked against a behavioural grid predictor held in the bench.
// Depends on lgse_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_life_grid_step_engine;

    localparam int COLS = 64;
    localparam int ROWS = 64;
    localparam int CYCLE_LIMIT = 30000000;
    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [lgse_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] cell_value;
        logic       coord_error;
        logic       bad_cell_seen;
        logic       wrap_refused;
    } life_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic [lgse_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [lgse_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [2:0] command = '0;
    logic [5:0] x_coord = '0;
    logic [5:0] y_coord = '0;
    logic [7:0] write_value = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [7:0] cell_value;
    logic coord_error;
    logic bad_cell_seen;
    logic wrap_refused;

    life_grid_step_engine DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .command(command), .x_coord(x_coord), .y_coord(y_coord),
        .write_value(write_value),
        .out_valid(out_valid), .out_stall(out_stall),
        .cell_value(cell_value), .coord_error(coord_error),
        .bad_cell_seen(bad_cell_seen), .wrap_refused(wrap_refused)
    );

    always #5 clk = ~clk;

    logic [7:0] model_grid [COLS*ROWS];
    logic [6:0] model_width = 7'd64;
    logic [6:0] model_height = 7'd64;
    logic       model_wrap = 1'b1;
    life_result_t awaited_results [$];
    int send_idle = 0;
    int recv_idle = 0;
    int fail_count = 0;
    int cycle_count = 0;

    function automatic int used_dim(input logic [6:0] v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic apply_command(input logic [2:0] cmd, input logic [5:0] x,
                                 input logic [5:0] y, input logic [7:0] wv,
                                 output life_result_t r);
        int w;
        int h;
        int sum;
        int nx;
        int ny;
        logic [7:0] old_grid [COLS*ROWS];
        logic [7:0] c;
        w = used_dim(model_width, COLS);
        h = used_dim(model_height, ROWS);
        r = '0;
        if (cmd == lgse_pkg::CMD_WRITE || cmd == lgse_pkg::CMD_READ
            || cmd == lgse_pkg::CMD_TOGGLE) begin
            if (x >= w || y >= h) begin
                r.coord_error = 1'b1;
            end
            else begin
                if (cmd == lgse_pkg::CMD_WRITE)
                    model_grid[y*COLS+x] = wv;
                else if (cmd == lgse_pkg::CMD_TOGGLE)
                    model_grid[y*COLS+x] = (model_grid[y*COLS+x] == 8'd1) ? 8'd0 : 8'd1;
                r.cell_value = model_grid[y*COLS+x];
            end
        end
        else if (cmd == lgse_pkg::CMD_STEP) begin
            if (!model_wrap) begin
                r.wrap_refused = 1'b1;
            end
            else begin
                old_grid = model_grid;
                for (int cy = 0; cy < h; cy++)
                    for (int cx = 0; cx < w; cx++)
                    begin
                        sum = 0;
                        for (int dy = -1; dy <= 1; dy++)
                            for (int dx = -1; dx <= 1; dx++)
                            begin
                                if (dx != 0 || dy != 0)
                                begin
                                    nx = (cx + w + dx) % w;
                                    ny = (cy + h + dy) % h;
                                    sum += old_grid[ny*COLS+nx];
                                end
                            end
                        c = old_grid[cy*COLS+cx];
                        if (c == 8'd1)
                            model_grid[cy*COLS+cx] = (sum == 2 || sum == 3) ? 8'd1 : 8'd0;
                        else if (c == 8'd0)
                            model_grid[cy*COLS+cx] = (sum == 3) ? 8'd1 : 8'd0;
                        else
                        begin
                            model_grid[cy*COLS+cx] = 8'd0;
                            r.bad_cell_seen = 1'b1;
                        end
                    end
            end
        end
        else if (cmd == lgse_pkg::CMD_CLEAR) begin
            foreach (model_grid[i]) model_grid[i] = 8'd0;
        end
    endtask

    task automatic send_word(input logic [2:0] cmd, input logic [5:0] x,
                             input logic [5:0] y, input logic [7:0] wv);
        life_result_t r;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        x_coord <= x;
        y_coord <= y;
        write_value <= wv;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        apply_command(cmd, x, y, wv, r);
        awaited_results.push_back(r);
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lgse_pkg::CFG_IDX_W-1:0] idx,
                             input logic [6:0] val);
        drain_results();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == lgse_pkg::REG_WIDTH) model_width = val;
        else if (idx == lgse_pkg::REG_HEIGHT) model_height = val;
        else if (idx == lgse_pkg::REG_WRAP) model_wrap = val[0];
    endtask

    always @(posedge clk)
    begin
        life_result_t got;
        life_result_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else if (rst_n && out_valid && !out_stall)
        begin
            got = {cell_value, coord_error, bad_cell_seen, wrap_refused};
            if (awaited_results.size() == 0)
            begin
                $display("%0t: result word with none awaited: %p", $time, got);
                fail_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (got.cell_value !== want.cell_value)
                begin
                    $display("%0t: cell_value exp %0d got %0d", $time, want.cell_value,
                             got.cell_value);
                    fail_count++;
                end
                if (got.coord_error !== want.coord_error)
                begin
                    $display("%0t: coord_error exp %0b got %0b", $time, want.coord_error,
                             got.coord_error);
                    fail_count++;
                end
                if (got.bad_cell_seen !== want.bad_cell_seen)
                begin
                    $display("%0t: bad_cell_seen exp %0b got %0b", $time,
                             want.bad_cell_seen, got.bad_cell_seen);
                    fail_count++;
                end
                if (got.wrap_refused !== want.wrap_refused)
                begin
                    $display("%0t: wrap_refused exp %0b got %0b", $time, want.wrap_refused,
                             got.wrap_refused);
                    fail_count++;
                end
            end
        end
        out_stall <= ($urandom_range(99) < recv_idle);
    end

    // full-size grid: corner writes, toggles, spare codes, one wrapped step
    task automatic test_full_grid;
        send_word(lgse_pkg::CMD_READ, 6'd63, 6'd63, 8'd0);
        send_word(lgse_pkg::CMD_WRITE, 6'd63, 6'd63, 8'd255);
        send_word(lgse_pkg::CMD_TOGGLE, 6'd63, 6'd63, 8'd0);
        send_word(lgse_pkg::CMD_TOGGLE, 6'd63, 6'd63, 8'd0);
        send_word(CMD_SPARE_LO, 6'd1, 6'd1, 8'd1);
        send_word(CMD_SPARE_HI, 6'd63, 6'd0, 8'd170);
        // blinker across the wrap corner plus one bad cell
        send_word(lgse_pkg::CMD_WRITE, 6'd63, 6'd0, 8'd1);
        send_word(lgse_pkg::CMD_WRITE, 6'd0, 6'd0, 8'd1);
        send_word(lgse_pkg::CMD_WRITE, 6'd1, 6'd0, 8'd1);
        send_word(lgse_pkg::CMD_WRITE, 6'd30, 6'd30, 8'd2);
        send_word(lgse_pkg::CMD_STEP, 6'd0, 6'd0, 8'd0);
        send_word(lgse_pkg::CMD_READ, 6'd0, 6'd63, 8'd0);
    endtask

    // degenerate sizes, clamping, refused step, spare register, untouched area
    task automatic test_sizes_and_wrap;
        write_reg(lgse_pkg::REG_WIDTH, 7'd0);
        write_reg(lgse_pkg::REG_HEIGHT, 7'd2);
        send_word(lgse_pkg::CMD_WRITE, 6'd0, 6'd1, 8'd1);
        send_word(lgse_pkg::CMD_WRITE, 6'd1, 6'd0, 8'd1);
        send_word(lgse_pkg::CMD_STEP, 6'd0, 6'd0, 8'd0);
        write_reg(lgse_pkg::REG_WIDTH, 7'd127);
        write_reg(lgse_pkg::REG_HEIGHT, 7'd3);
        send_word(lgse_pkg::CMD_READ, 6'd5, 6'd3, 8'd0);
        send_word(lgse_pkg::CMD_STEP, 6'd0, 6'd0, 8'd0);
        write_reg(lgse_pkg::REG_WRAP, 7'd0);
        write_reg(REG_SPARE, 7'd1);
        send_word(lgse_pkg::CMD_STEP, 6'd0, 6'd0, 8'd0);
        write_reg(lgse_pkg::REG_WRAP, 7'd1);
        write_reg(lgse_pkg::REG_HEIGHT, 7'd64);
        send_word(lgse_pkg::CMD_READ, 6'd30, 6'd30, 8'd0);
        send_word(lgse_pkg::CMD_CLEAR, 6'd0, 6'd0, 8'd0);
        send_word(lgse_pkg::CMD_READ, 6'd0, 6'd63, 8'd0);
    endtask

    task automatic random_block(input int items);
        logic [2:0] cmd;
        logic [5:0] x;
        logic [5:0] y;
        logic [7:0] wv;
        int pick;
        int w;
        int h;
        write_reg(lgse_pkg::REG_WIDTH, ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                                 : 7'($urandom_range(1, 10)));
        write_reg(lgse_pkg::REG_HEIGHT, ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                                                  : 7'($urandom_range(1, 10)));
        write_reg(lgse_pkg::REG_WRAP, ($urandom_range(7) == 0) ? 7'd0 : 7'd1);
        w = used_dim(model_width, COLS);
        h = used_dim(model_height, ROWS);
        // large grids: keep steps rare
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            wv = ($urandom_range(5) == 0) ? 8'($urandom) : 8'($urandom_range(1));
            x = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(w - 1));
            y = ($urandom_range(7) == 0) ? 6'($urandom) : 6'($urandom_range(h - 1));
            if (pick < 45) cmd = lgse_pkg::CMD_WRITE;
            else if (pick < 60) cmd = lgse_pkg::CMD_READ;
            else if (pick < 75) cmd = lgse_pkg::CMD_TOGGLE;
            else if (pick < 93)
                cmd = (w * h > 400 && pick > 77) ? lgse_pkg::CMD_READ : lgse_pkg::CMD_STEP;
            else if (pick < 96) cmd = lgse_pkg::CMD_CLEAR;
            else cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
            send_word(cmd, x, y, wv);
        end
    endtask

    task automatic test_random_phase(input int s_idle, input int r_idle);
        send_idle = s_idle;
        recv_idle = r_idle;
        for (int b = 0; b < 3; b++)
            random_block(13);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        send_idle = 30;
        recv_idle = 78;
        test_full_grid();
        test_sizes_and_wrap();
        test_random_phase(30, 78);
        test_random_phase(78, 30);
        test_random_phase(0, 0);
        drain_results();
        repeat (40) @(posedge clk);
        if (fail_count == 0 && awaited_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
